// ----- hdl/satd_pkg.sv -----
// Shared widths, types and the 4-point Hadamard butterfly for the 8x16 SATD block.
// No dependencies; imported by every module under hdl/.
package satd_pkg;

  localparam int PIX_W          = 8;
  localparam int LANES          = 8;
  localparam int GRP_ROWS       = 4;
  localparam int DIFF_W         = 9;
  localparam int COL_W          = 11;
  localparam int COEF_W         = 13;
  localparam int ABS_W          = 12;
  localparam int PSUM_W         = 15;
  localparam int GSUM_W         = 17;
  localparam int SATD_W         = 18;
  localparam int ROW_BITS       = LANES * PIX_W;
  localparam int GRP_DIFFS      = GRP_ROWS * LANES;
  localparam int GROUP_MAX      = 130560;
  localparam int BLOCK_ROWS_DEF = 16;
  localparam int Q_DEPTH        = 2;
  localparam int Q_AW           = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CW           = $clog2(Q_DEPTH + 1);

  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef coef_t [3:0]              quad_t;

  // One request handed from the front to the back.
  typedef struct packed {
    logic                    last;
    logic                    grp;
    diff_t [GRP_DIFFS-1:0]   diff;
  } grp_req_t;

  function automatic quad_t hadamard4(quad_t x);
    coef_t s01;
    coef_t d01;
    coef_t s23;
    coef_t d23;
    quad_t y;
    s01  = x[0] + x[1];
    d01  = x[0] - x[1];
    s23  = x[2] + x[3];
    d23  = x[2] - x[3];
    y[0] = s01 + s23;
    y[1] = s01 - s23;
    y[2] = d01 - d23;
    y[3] = d01 + d23;
    return y;
  endfunction

endpackage

// ----- hdl/satd_hadamard_8x16.sv -----
// Top level of the 8-column 4x4 Hadamard SATD block: front end, request queue, back end.
// Path from the request carrying the last row to out_valid: queue entry, stages s1, s2, s3, then the output register.
// Throughput: one row per cycle while in_stall is low; the 2-entry queue and the stalled back pipeline set the pace.
// Reset: synchronous rst_n clears row count, queue, pipeline valids and running sum.
// The difference rows need no reset: each is written before the group reads it.
module satd_hadamard_8x16 import satd_pkg::*; #(
  parameter int BLOCK_ROWS = BLOCK_ROWS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [ROW_BITS-1:0] in_row_a,
  input  logic [ROW_BITS-1:0] in_row_b,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [SATD_W-1:0]   out_satd_value
);

  logic     push;
  grp_req_t push_req;
  logic     q_full;
  logic     q_pop;
  logic     q_valid;
  grp_req_t q_req;

  satd_front #(.BLOCK_ROWS(BLOCK_ROWS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_row_a (in_row_a),
    .in_row_b (in_row_b),
    .q_full   (q_full),
    .push     (push),
    .push_req (push_req)
  );

  satd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_req (push_req),
    .q_full   (q_full),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_req    (q_req)
  );

  satd_back #(.BLOCK_ROWS(BLOCK_ROWS)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_req          (q_req),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_satd_value (out_satd_value)
  );

endmodule

// ----- hdl/satd_front.sv -----
// Front end: accepts pixel rows, forms differences, keeps the group's first three rows
// and issues a request on each completed group or block end. Uses satd_pkg.
module satd_front import satd_pkg::*; #(
  parameter int BLOCK_ROWS = BLOCK_ROWS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [ROW_BITS-1:0] in_row_a,
  input  logic [ROW_BITS-1:0] in_row_b,
  input  logic                q_full,
  output logic                push,
  output grp_req_t            push_req
);

  localparam int ROW_W = $clog2(BLOCK_ROWS);
  localparam logic [1:0] LAST_POS = 2'(GRP_ROWS - 1);

  logic [ROW_W-1:0]                row_idx_r, row_idx_nxt;
  diff_t [GRP_ROWS-2:0][LANES-1:0] diff_rows_r;
  diff_t [LANES-1:0]               diff_cur;
  logic [1:0]                      pos;
  logic                            last_row;
  logic                            accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign pos      = row_idx_r[1:0];
  assign last_row = (row_idx_r == ROW_W'(BLOCK_ROWS - 1));
  assign push     = accept && ((pos == LAST_POS) || last_row);

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      diff_cur[k] = {1'b0, in_row_a[k*PIX_W +: PIX_W]} - {1'b0, in_row_b[k*PIX_W +: PIX_W]};
    end
  end

  always_comb begin
    push_req.last = last_row;
    push_req.grp  = (pos == LAST_POS);
    for (int r = 0; r < GRP_ROWS - 1; r++) begin
      for (int k = 0; k < LANES; k++) begin
        push_req.diff[r*LANES + k] = diff_rows_r[r][k];
      end
    end
    for (int k = 0; k < LANES; k++) begin
      push_req.diff[(GRP_ROWS-1)*LANES + k] = diff_cur[k];
    end
  end

  always_comb begin
    row_idx_nxt = row_idx_r;
    if (accept) begin
      row_idx_nxt = last_row ? '0 : row_idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_idx_r <= '0;
    end else begin
      row_idx_r <= row_idx_nxt;
    end
  end

  // Hold the first three rows of the group; the fourth goes straight out.
  always_ff @(posedge clk) begin
    if (accept && (pos != LAST_POS)) begin
      diff_rows_r[pos] <= diff_cur;
    end
  end

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    row_idx_r <= ROW_W'(BLOCK_ROWS - 1))
    else $error("row index beyond block height");

endmodule

// ----- hdl/satd_queue.sv -----
// Short request queue between front and back so each side stalls on its own.
// Register storage, read at the head pointer. Uses satd_pkg.
module satd_queue import satd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  grp_req_t push_req,
  output logic     q_full,
  input  logic     pop,
  output logic     q_valid,
  output grp_req_t q_req
);

  grp_req_t [Q_DEPTH-1:0] mem_r;
  logic [Q_AW-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0]        count_r, count_nxt;

  assign q_full  = (count_r == Q_CW'(Q_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_req   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_req;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("request pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("request popped from empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Q_CW'(Q_DEPTH))
    else $error("queue count out of range");

endmodule

// ----- hdl/satd_back.sv -----
// Back end: column and row Hadamard stages, absolute-value sum tree, block
// accumulator and output register. Consumes requests from satd_queue. Uses satd_pkg.
module satd_back import satd_pkg::*; #(
  parameter int BLOCK_ROWS = BLOCK_ROWS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  grp_req_t          q_req,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [SATD_W-1:0] out_satd_value
);

  localparam int ACC_W = $clog2((BLOCK_ROWS / GRP_ROWS) * GROUP_MAX + 1);
  localparam int SUB   = LANES / 4;

  logic en;

  logic                                   s1_valid_r, s1_last_r, s1_grp_r;
  logic [GRP_ROWS-1:0][LANES-1:0][COL_W-1:0] s1_col_r, s1_col_nxt;
  logic                                   s2_valid_r, s2_last_r, s2_grp_r;
  logic [GRP_DIFFS-1:0][ABS_W-1:0]        s2_abs_r, s2_abs_nxt;
  logic                                   s3_valid_r, s3_last_r, s3_grp_r;
  logic [3:0][PSUM_W-1:0]                 s3_psum_r, s3_psum_nxt;
  logic [GSUM_W-1:0]                      gsum;
  logic [ACC_W-1:0]                       acc_r, total;
  logic                                   out_valid_r;
  logic [SATD_W-1:0]                      out_value_r;
  logic [ACC_W+SATD_W-1:0]                total_ext;

  // Whole back pipeline advances unless a finished result is held.
  assign en    = !(out_valid_r && out_stall);
  assign q_pop = en && q_valid;

  // Vertical transform, one butterfly per column.
  always_comb begin
    quad_t x;
    quad_t y;
    for (int c = 0; c < LANES; c++) begin
      for (int r = 0; r < GRP_ROWS; r++) begin
        x[r] = {{(COEF_W-DIFF_W){q_req.diff[r*LANES + c][DIFF_W-1]}}, q_req.diff[r*LANES + c]};
      end
      y = hadamard4(x);
      for (int r = 0; r < GRP_ROWS; r++) begin
        s1_col_nxt[r][c] = y[r][COL_W-1:0];
      end
    end
  end

  // Horizontal transform within each sub-block, then magnitude.
  always_comb begin
    quad_t x;
    quad_t y;
    coef_t v;
    for (int b = 0; b < SUB; b++) begin
      for (int r = 0; r < GRP_ROWS; r++) begin
        for (int c = 0; c < 4; c++) begin
          x[c] = {{(COEF_W-COL_W){s1_col_r[r][b*4 + c][COL_W-1]}}, s1_col_r[r][b*4 + c]};
        end
        y = hadamard4(x);
        for (int c = 0; c < 4; c++) begin
          v = y[c][COEF_W-1] ? -y[c] : y[c];
          s2_abs_nxt[b*16 + r*4 + c] = v[ABS_W-1:0];
        end
      end
    end
  end

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      s3_psum_nxt[j] = '0;
      for (int i = 0; i < 8; i++) begin
        s3_psum_nxt[j] = s3_psum_nxt[j] + PSUM_W'(s2_abs_r[j*8 + i]);
      end
    end
  end

  always_comb begin
    gsum = GSUM_W'(s3_psum_r[0]) + GSUM_W'(s3_psum_r[1])
         + GSUM_W'(s3_psum_r[2]) + GSUM_W'(s3_psum_r[3]);
    total     = acc_r + (s3_grp_r ? ACC_W'(gsum) : '0);
    total_ext = {{SATD_W{1'b0}}, total};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
    end else if (en) begin
      s1_valid_r  <= q_valid;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      out_valid_r <= s3_valid_r && s3_last_r;
      if (s3_valid_r) begin
        acc_r <= s3_last_r ? '0 : total;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_last_r  <= q_req.last;
      s1_grp_r   <= q_req.grp;
      s1_col_r   <= s1_col_nxt;
      s2_last_r  <= s1_last_r;
      s2_grp_r   <= s1_grp_r;
      s2_abs_r   <= s2_abs_nxt;
      s3_last_r  <= s2_last_r;
      s3_grp_r   <= s2_grp_r;
      s3_psum_r  <= s3_psum_nxt;
      if (s3_valid_r && s3_last_r) begin
        out_value_r <= total_ext[SATD_W:1];
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_satd_value = out_value_r;

  a_out_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s3_valid_r && s3_last_r))
    else $error("result raised without a block end");

  a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (en && s3_valid_r && s3_last_r) |=> (acc_r == '0))
    else $error("accumulator not cleared after block end");

endmodule
